@@ rtl/sm3_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// SM3 package
// Shared constants, command and status types, and round functions for the
// SM3 hash engine.
// ---------------------------------------------------------------------------
package sm3_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned BlockWords = 16;
  localparam int unsigned Rounds = 64;

  localparam logic [WordW-1:0] Iv [8] = '{
    32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
    32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e
  };
  localparam logic [WordW-1:0] TjLow = 32'h79cc4519;
  localparam logic [WordW-1:0] TjHigh = 32'h7a879d8a;
  localparam logic [7:0] PadByte = 8'h80;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_word;     // merge an input word into the block buffer
    logic pad_start;     // write pad byte and zero fill at the fill point
    logic zero_block;    // zero the whole buffer (extra padding block)
    logic put_length;    // write the bit length into the last two words
    logic start_comp;    // latch the buffer and chaining value, round 0
    logic round_step;    // run one compression round
    logic finish_comp;   // fold working variables into the chaining value
    logic shift_digest;  // move to the next digest word
    logic reset_chain;   // reload the initial vector and clear the count
  } sm3_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic       block_full;  // this word fills the buffer to 64 bytes
    logic       need_extra;  // padding needs an extra block
    logic       last_round;  // round counter at 63
  } sm3_sts_t;

  function automatic logic [WordW-1:0] rotl(input logic [WordW-1:0] x,
                                            input logic [4:0] n);
    logic [2*WordW-1:0] t;
    t = {x, x} << n;
    return t[2*WordW-1:WordW];
  endfunction

  function automatic logic [WordW-1:0] perm0(input logic [WordW-1:0] x);
    return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
  endfunction

  function automatic logic [WordW-1:0] perm1(input logic [WordW-1:0] x);
    return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
  endfunction

endpackage
`default_nettype wire

@@ rtl/sm3_datapath.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// SM3 datapath
// Block buffer, byte counter, message schedule window, working variables
// and chaining value. One compression round per cycle.
// ---------------------------------------------------------------------------
module sm3_datapath
  import sm3_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire sm3_cmd_t         cmd_i,
  input  wire logic [WordW-1:0] data_word_i,
  input  wire logic [2:0]       byte_count_i,
  output sm3_sts_t              sts_o,
  output logic [WordW-1:0]      digest_word_o
);

  logic [WordW-1:0] buf_q [BlockWords];
  logic [WordW-1:0] spill_q;
  logic [63:0]      total_q;
  logic [WordW-1:0] cv_q [8];
  logic [WordW-1:0] w_q [BlockWords];
  logic [WordW-1:0] a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q;
  logic [5:0]       round_q;
  logic [WordW-1:0] tj_rot_q;

  logic [2:0] cnt;
  logic [5:0] fill;
  logic [3:0] widx;
  logic [1:0] boff;
  logic [WordW-1:0] wbytes;
  logic [6:0] fill_after;

  assign cnt = (byte_count_i > 3'd4) ? 3'd4 : byte_count_i;
  assign fill = total_q[5:0];
  assign widx = fill[5:2];
  assign boff = fill[1:0];
  assign fill_after = {1'b0, fill} + 7'(cnt);

  // Bytes of the input word placed at the fill position; the leading bytes
  // are written here, spillover goes into the next buffer word.
  logic [2*WordW-1:0] place;
  logic [WordW-1:0]   mask;
  logic [WordW-1:0]   cmask;
  always_comb begin
    cmask = '0;
    unique case (cnt)
      3'd1: cmask = 32'hff000000;
      3'd2: cmask = 32'hffff0000;
      3'd3: cmask = 32'hffffff00;
      3'd4: cmask = 32'hffffffff;
      default: cmask = '0;
    endcase
    place = {data_word_i & cmask, 32'h0} >> {boff, 3'b000};
    mask = cmask >> {boff, 3'b000};
  end

  // Padding mask: keep bytes before the fill point, pad byte at the fill
  // point, zeros after.
  logic [WordW-1:0] keep_mask, pad_bits;
  always_comb begin
    keep_mask = ~(32'hffffffff >> {boff, 3'b000});
    pad_bits = {PadByte, 24'h0} >> {boff, 3'b000};
  end

  logic [63:0] bits;
  assign bits = {total_q[60:0], 3'b000};

  // Round logic.
  logic [WordW-1:0] a12, ss1, ss2, ff, gg, tt1, tt2, wn;
  logic             hi;
  always_comb begin
    hi = (round_q >= 6'd16);
    a12 = rotl(a_q, 5'd12);
    ss1 = rotl(a12 + e_q + tj_rot_q, 5'd7);
    ss2 = ss1 ^ a12;
    ff = hi ? ((a_q & b_q) | (a_q & c_q) | (b_q & c_q)) : (a_q ^ b_q ^ c_q);
    gg = hi ? ((e_q & f_q) | (~e_q & g_q)) : (e_q ^ f_q ^ g_q);
    tt1 = ff + d_q + ss2 + (w_q[0] ^ w_q[4]);
    tt2 = gg + h_q + ss1 + w_q[0];
    wn = perm1(w_q[0] ^ w_q[7] ^ rotl(w_q[13], 5'd15)) ^ rotl(w_q[3], 5'd7) ^ w_q[10];
  end

  // Block buffer and byte count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
    end else if (cmd_i.reset_chain) begin
      total_q <= '0;
    end else if (cmd_i.load_word) begin
      total_q <= total_q + 64'(cnt);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_word) begin
      buf_q[widx] <= (buf_q[widx] & ~mask) | place[63:32];
      if (widx != 4'd15) begin
        buf_q[widx + 4'd1] <= place[31:0];
      end else begin
        spill_q <= place[31:0];
      end
    end else if (cmd_i.start_comp) begin
      // Bytes that ran past the end of the block open the next one.
      buf_q[0] <= spill_q;
    end else if (cmd_i.zero_block) begin
      for (int i = 0; i < BlockWords; i++) buf_q[i] <= '0;
    end else if (cmd_i.pad_start) begin
      buf_q[widx] <= (buf_q[widx] & keep_mask) | pad_bits;
      for (int i = 0; i < BlockWords; i++) begin
        if (4'(i) > widx) buf_q[i] <= '0;
      end
    end else if (cmd_i.put_length) begin
      buf_q[14] <= bits[63:32];
      buf_q[15] <= bits[31:0];
    end
  end

  // Compression state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) cv_q[i] <= Iv[i];
      round_q <= '0;
    end else if (cmd_i.reset_chain) begin
      for (int i = 0; i < 8; i++) cv_q[i] <= Iv[i];
    end else if (cmd_i.start_comp) begin
      round_q <= '0;
    end else if (cmd_i.round_step) begin
      round_q <= round_q + 6'd1;
    end else if (cmd_i.finish_comp) begin
      cv_q[0] <= cv_q[0] ^ a_q; cv_q[1] <= cv_q[1] ^ b_q;
      cv_q[2] <= cv_q[2] ^ c_q; cv_q[3] <= cv_q[3] ^ d_q;
      cv_q[4] <= cv_q[4] ^ e_q; cv_q[5] <= cv_q[5] ^ f_q;
      cv_q[6] <= cv_q[6] ^ g_q; cv_q[7] <= cv_q[7] ^ h_q;
    end else if (cmd_i.shift_digest) begin
      for (int i = 0; i < 7; i++) cv_q[i] <= cv_q[i + 1];
      cv_q[7] <= cv_q[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_comp) begin
      for (int i = 0; i < BlockWords; i++) w_q[i] <= buf_q[i];
      a_q <= cv_q[0]; b_q <= cv_q[1]; c_q <= cv_q[2]; d_q <= cv_q[3];
      e_q <= cv_q[4]; f_q <= cv_q[5]; g_q <= cv_q[6]; h_q <= cv_q[7];
      tj_rot_q <= TjLow;
    end else if (cmd_i.round_step) begin
      for (int i = 0; i < BlockWords - 1; i++) w_q[i] <= w_q[i + 1];
      w_q[BlockWords-1] <= wn;
      d_q <= c_q; c_q <= rotl(b_q, 5'd9); b_q <= a_q; a_q <= tt1;
      h_q <= g_q; g_q <= rotl(f_q, 5'd19); f_q <= e_q; e_q <= perm0(tt2);
      // T_j rotated by the next round index.
      tj_rot_q <= (round_q == 6'd15) ? rotl(TjHigh, 5'd16) : rotl(tj_rot_q, 5'd1);
    end
  end

  assign sts_o.block_full = fill_after[6];
  assign sts_o.need_extra = (fill > 6'd55);
  assign sts_o.last_round = (round_q == 6'(Rounds - 1));
  assign digest_word_o = cv_q[0];

endmodule
`default_nettype wire

@@ rtl/sm3_ctrl.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// SM3 controller
// Sequences word intake, padding, compression rounds and digest output.
// ---------------------------------------------------------------------------
module sm3_ctrl
  import sm3_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  input  wire logic in_last_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output logic      out_last_o,
  input  wire sm3_sts_t sts_i,
  output sm3_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    StIdle, StRound, StFinish, StPad, StLen, StExtra, StOut
  } state_e;

  state_e     state_q, state_d;
  logic       fin_q, fin_d;      // padding continues after this block
  logic       padded_q, padded_d; // pad byte already written
  logic [2:0] out_cnt_q, out_cnt_d;
  logic       accept;
  logic       last_block_q, last_block_d;

  assign in_ready_o = (state_q == StIdle);
  assign accept = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == StOut);
  assign out_last_o = (out_cnt_q == 3'd7);

  always_comb begin
    state_d = state_q;
    fin_d = fin_q;
    padded_d = padded_q;
    out_cnt_d = out_cnt_q;
    cmd_o = '0;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          cmd_o.load_word = 1'b1;
          fin_d = in_last_i;
          padded_d = 1'b0;
          if (sts_i.block_full) begin
            state_d = StExtra;
          end else if (in_last_i) begin
            state_d = StPad;
          end
        end
      end
      StExtra: begin
        // A full block is ready in the buffer: data, padding or length.
        cmd_o.start_comp = 1'b1;
        state_d = StRound;
      end
      StPad: begin
        if (padded_q) begin
          cmd_o.zero_block = 1'b1;
          state_d = StLen;
        end else begin
          cmd_o.pad_start = 1'b1;
          padded_d = 1'b1;
          if (sts_i.need_extra) begin
            state_d = StExtra;
            fin_d = 1'b1;
          end else begin
            state_d = StLen;
          end
        end
      end
      StLen: begin
        cmd_o.put_length = 1'b1;
        padded_d = 1'b0;
        fin_d = 1'b0;
        state_d = StExtra;
      end
      StRound: begin
        cmd_o.round_step = 1'b1;
        if (sts_i.last_round) state_d = StFinish;
      end
      StFinish: begin
        cmd_o.finish_comp = 1'b1;
        if (fin_q) begin
          state_d = StPad;
        end else if (padded_q) begin
          state_d = StIdle;
        end else begin
          state_d = StIdle;
        end
        if (!fin_q && last_block_q) begin
          state_d = StOut;
          out_cnt_d = '0;
        end
      end
      StOut: begin
        if (out_ready_i) begin
          cmd_o.shift_digest = 1'b1;
          out_cnt_d = out_cnt_q + 3'd1;
          if (out_last_o) begin
            cmd_o.shift_digest = 1'b0;
            cmd_o.reset_chain = 1'b1;
            state_d = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // The block that carries the length is the final one of the message.
  always_comb begin
    last_block_d = last_block_q;
    if (state_q == StLen) last_block_d = 1'b1;
    else if (state_q == StOut) last_block_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      fin_q <= 1'b0;
      padded_q <= 1'b0;
      out_cnt_q <= '0;
      last_block_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fin_q <= fin_d;
      padded_q <= padded_d;
      out_cnt_q <= out_cnt_d;
      last_block_q <= last_block_d;
    end
  end

  // A digest word is never offered while input is being taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(in_ready_o && out_valid_o))
    else $error("input and output active together");
  // The fold step is only ever entered straight from the rounds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StFinish) |-> $past(state_q == StRound))
    else $error("finish without rounds");
  // After the eighth digest word the engine is idle again.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && out_last_o) |=> in_ready_o)
    else $error("engine not idle after digest");

endmodule
`default_nettype wire

@@ rtl/sm3_hash_engine_core.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// SM3 hash engine
// Buffers message words into 64-byte blocks, compresses each block, pads
// the final block and streams out the eight digest words.
// ---------------------------------------------------------------------------
// Channel  Dir  Fields
// s_axis   in   tdata[31:0]=data_word, tuser[2:0]=byte_count, tlast=last
// m_axis   out  tdata[31:0]=digest_word, tlast=digest_last
//
// A word is taken only while idle. A filled block runs start, 64 rounds
// on the single round unit, and a fold into the chaining value. The last
// word adds padding and length steps plus one or two blocks, then eight
// digest words, one per cycle while m_axis_tready is high.
// Reset is asynchronous and loads the initial vector; no clearing pass.
// ---------------------------------------------------------------------------
module sm3_hash_engine_core
  import sm3_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // data_word
  input  wire logic [2:0]  s_axis_tuser,  // byte_count
  input  wire logic        s_axis_tlast,  // last
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,  // digest_word
  output logic             m_axis_tlast   // digest_last
);

  sm3_cmd_t cmd;
  sm3_sts_t sts;

  sm3_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_last_i   (s_axis_tlast),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_last_o  (m_axis_tlast),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  sm3_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .data_word_i   (s_axis_tdata),
    .byte_count_i  (s_axis_tuser),
    .sts_o         (sts),
    .digest_word_o (m_axis_tdata)
  );

endmodule
`default_nettype wire

@@ sim/tb.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// SM3 hash engine testbench
// Streams messages of random length and content into the engine, computes
// the expected digest of each message alongside, and checks every digest
// word and its last flag as they come out. Both sides idle at random.
// ---------------------------------------------------------------------------
module tb;
  import sm3_pkg::*;

  typedef struct packed {
    logic [31:0] data;
    logic [2:0]  nbytes;
    logic        last;
  } msg_word_t;

  typedef struct packed {
    logic [31:0] data;
    logic        last;
  } digest_word_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic [2:0]  s_axis_tuser;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;

  sm3_hash_engine_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Clock.
  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  msg_word_t    pending_words[$];
  digest_word_t digest_queue[$];
  int           error_count;
  bit           calm;      // no idling on either side while set
  bit           hold_send; // sender waits while set

  // Predictor state: chaining value, block buffer and byte count.
  logic [31:0] chain[8];
  logic [7:0]  block_buf[64];
  logic [63:0] total_bytes;

  function automatic logic [31:0] rol(logic [31:0] x, int n);
    n = n % 32;
    if (n == 0) return x;
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic logic [31:0] mix0(logic [31:0] x);
    return x ^ rol(x, 9) ^ rol(x, 17);
  endfunction

  function automatic logic [31:0] mix1(logic [31:0] x);
    return x ^ rol(x, 15) ^ rol(x, 23);
  endfunction

  task automatic compress_buffer();
    logic [31:0] w[68];
    logic [31:0] a, b, c, d, e, f, g, h, tj, a12, ss1, ss2, ff, gg, tt1, tt2;
    for (int j = 0; j < 16; j++)
      w[j] = {block_buf[4*j], block_buf[4*j+1], block_buf[4*j+2], block_buf[4*j+3]};
    for (int j = 16; j < 68; j++)
      w[j] = mix1(w[j-16] ^ w[j-9] ^ rol(w[j-3], 15)) ^ rol(w[j-13], 7) ^ w[j-6];
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
    e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
    for (int j = 0; j < 64; j++) begin
      tj = (j < 16) ? TjLow : TjHigh;
      a12 = rol(a, 12);
      ss1 = rol(a12 + e + rol(tj, j), 7);
      ss2 = ss1 ^ a12;
      if (j < 16) begin
        ff = a ^ b ^ c;
        gg = e ^ f ^ g;
      end else begin
        ff = (a & b) | (a & c) | (b & c);
        gg = (e & f) | (~e & g);
      end
      tt1 = ff + d + ss2 + (w[j] ^ w[j+4]);
      tt2 = gg + h + ss1 + w[j];
      d = c; c = rol(b, 9); b = a; a = tt1;
      h = g; g = rol(f, 19); f = e; e = mix0(tt2);
    end
    chain[0] ^= a; chain[1] ^= b; chain[2] ^= c; chain[3] ^= d;
    chain[4] ^= e; chain[5] ^= f; chain[6] ^= g; chain[7] ^= h;
  endtask

  task automatic restart_hash();
    for (int k = 0; k < 8; k++) chain[k] = Iv[k];
    total_bytes = '0;
  endtask

  task automatic absorb_byte(logic [7:0] v);
    int pos;
    pos = int'(total_bytes[5:0]);
    block_buf[pos] = v;
    total_bytes = total_bytes + 64'd1;
    if (pos == 63) compress_buffer();
  endtask

  // Expected digest words for one accepted message word.
  task automatic predict_digest(msg_word_t mw);
    int          cnt;
    int          pos;
    logic [63:0] bit_len;
    digest_word_t dw;
    cnt = (mw.nbytes > 3'd4) ? 4 : int'(mw.nbytes);
    for (int k = 0; k < cnt; k++) absorb_byte(mw.data[31-8*k -: 8]);
    if (!mw.last) return;
    bit_len = total_bytes << 3;
    pos = int'(total_bytes[5:0]);
    block_buf[pos] = PadByte;
    pos++;
    if (pos > 56) begin
      for (int k = pos; k < 64; k++) block_buf[k] = 8'h00;
      compress_buffer();
      pos = 0;
    end
    for (int k = pos; k < 56; k++) block_buf[k] = 8'h00;
    for (int k = 0; k < 8; k++) block_buf[56+k] = bit_len[63-8*k -: 8];
    compress_buffer();
    for (int k = 0; k < 8; k++) begin
      dw.data = chain[k];
      dw.last = (k == 7);
      digest_queue.push_back(dw);
    end
    restart_hash();
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch: %s got %h expected %h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Driver: presents pending words, idling at random.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
      s_axis_tlast  <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_digest({s_axis_tdata, s_axis_tuser, s_axis_tlast});
        void'(pending_words.pop_front());
      end
      if (pending_words.size() > 0 && !hold_send &&
          (calm || $urandom_range(99) >= 20)) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pending_words[0].data;
        s_axis_tuser  <= pending_words[0].nbytes;
        s_axis_tlast  <= pending_words[0].last;
      end else if (!(s_axis_tvalid && !s_axis_tready)) begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: checks digest words and stalls the output at random.
  always @(posedge clk_i or negedge rst_ni) begin
    digest_word_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (digest_queue.size() == 0) begin
          report_mismatch("unexpected digest word", m_axis_tdata, '0);
        end else begin
          want = digest_queue.pop_front();
          if (m_axis_tdata !== want.data)
            report_mismatch("digest_word", m_axis_tdata, want.data);
          if (m_axis_tlast !== want.last)
            report_mismatch("digest_last", 32'(m_axis_tlast), 32'(want.last));
        end
      end
      m_axis_tready <= calm || ($urandom_range(99) >= 20);
    end
  end

  // Queues one message; with ragged clear every word is full, otherwise
  // the byte counts are random.
  task automatic add_message(int nwords, bit ragged, bit empty_tail);
    msg_word_t mw;
    for (int i = 0; i < nwords; i++) begin
      mw.data   = $urandom();
      mw.nbytes = ragged ? 3'($urandom_range(7)) : 3'd4;
      mw.last   = (i == nwords - 1) && !empty_tail;
      if (mw.last && ragged && $urandom_range(3) == 0) mw.nbytes = 3'd0;
      pending_words.push_back(mw);
    end
    if (empty_tail) begin
      mw.data   = $urandom();
      mw.nbytes = 3'd0;
      mw.last   = 1'b1;
      pending_words.push_back(mw);
    end
  endtask

  task automatic wait_drained();
    while (pending_words.size() > 0 || s_axis_tvalid || digest_queue.size() > 0)
      @(posedge clk_i);
  endtask

  // Stimulus.
  initial begin
    int        sent;
    error_count   = 0;
    calm          = 1'b0;
    hold_send     = 1'b0;
    restart_hash();
    for (int k = 0; k < 64; k++) block_buf[k] = 8'h00;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: the standard "abc" message, an empty message, extremes.
    pending_words.push_back('{32'h61626300, 3'd3, 1'b1});
    pending_words.push_back('{32'hffffffff, 3'd0, 1'b1});
    pending_words.push_back('{32'hffffffff, 3'd4, 1'b0});
    pending_words.push_back('{32'h00000000, 3'd0, 1'b0});
    pending_words.push_back('{32'hffffffff, 3'd7, 1'b0});
    pending_words.push_back('{32'h12345678, 3'd5, 1'b0});
    pending_words.push_back('{32'h00000000, 3'd6, 1'b1});
    pending_words.push_back('{32'hdeadbeef, 3'd1, 1'b0});
    pending_words.push_back('{32'hcafef00d, 3'd2, 1'b1});
    // 56 bytes then finish: needs an extra padding block.
    add_message(14, 1'b0, 1'b1);
    // Exactly one block, then padding in a fresh block.
    add_message(16, 1'b0, 1'b0);

    // Pause until every digest of the directed part has arrived.
    hold_send = 1'b1;
    @(posedge clk_i);
    hold_send = 1'b0;
    wait_drained();

    // Random messages, mostly short, a few spanning several blocks.
    sent = 0;
    while (sent < 320) begin
      int nw;
      nw = ($urandom_range(9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
      add_message(nw, 1'($urandom_range(1)), $urandom_range(5) == 0);
      sent += nw;
      if (sent > 150 && sent < 220) calm = 1'b1;
      else calm = 1'b0;
      while (pending_words.size() > 20) @(posedge clk_i);
    end

    wait_drained();
    repeat (200) @(posedge clk_i);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Timeout.
  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
